>>> hdl/b64d_pkg.sv
package b64d_pkg;

    // Longest stream the byte counter is sized for, in input characters.
    localparam longint unsigned MAX_IN_CHARS = 64'd16777215;

    localparam int COUNT_W = 24;

    // Three bytes per started group of four characters, capped at the counter width.
    localparam longint unsigned COUNT_RAW  = ((MAX_IN_CHARS + 64'd3) / 64'd4) * 64'd3;
    localparam longint unsigned COUNT_MAXV = (64'd1 << COUNT_W) - 64'd1;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (COUNT_RAW > COUNT_MAXV) ? COUNT_MAXV[COUNT_W-1:0] : COUNT_RAW[COUNT_W-1:0];

    typedef enum logic [1:0] {
        SYM_DATA = 2'd0,
        SYM_SKIP = 2'd1,
        SYM_BAD  = 2'd2
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t   kind;
        logic [5:0]  value;
    } sym_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2,
        PH_FOURTH = 2'd3
    } phase_t;

endpackage

>>> hdl/b64d_classify.sv
module b64d_classify (
    input  logic [7:0]    in_char,
    output b64d_pkg::sym_t sym
);

    logic [7:0] upper_off;
    logic [7:0] lower_off;
    logic [7:0] digit_off;

    assign upper_off = in_char - 8'h41;
    assign lower_off = in_char - 8'h61 + 8'd26;
    assign digit_off = in_char - 8'h30 + 8'd52;

    // Both alphabets map onto one 6-bit symbol; whitespace and padding are skipped.
    always_comb
    begin
        sym.kind  = b64d_pkg::SYM_BAD;
        sym.value = 6'd0;
        case (in_char) inside
            [8'h41:8'h5A]:
            begin
                sym.kind  = b64d_pkg::SYM_DATA;
                sym.value = upper_off[5:0];
            end
            [8'h61:8'h7A]:
            begin
                sym.kind  = b64d_pkg::SYM_DATA;
                sym.value = lower_off[5:0];
            end
            [8'h30:8'h39]:
            begin
                sym.kind  = b64d_pkg::SYM_DATA;
                sym.value = digit_off[5:0];
            end
            8'h2B, 8'h2D:
            begin
                sym.kind  = b64d_pkg::SYM_DATA;
                sym.value = 6'd62;
            end
            8'h2F, 8'h5F:
            begin
                sym.kind  = b64d_pkg::SYM_DATA;
                sym.value = 6'd63;
            end
            8'h09, 8'h0A, 8'h0D, 8'h20, 8'h3D:
            begin
                sym.kind  = b64d_pkg::SYM_SKIP;
            end
            default:
            begin
                sym.kind  = b64d_pkg::SYM_BAD;
            end
        endcase
    end

endmodule

>>> hdl/b64d_accum.sv
module b64d_accum (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sym_valid,
    input  b64d_pkg::sym_t                   sym,
    input  logic                             sym_last,
    output logic                             room,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [7:0]                       out_byte,
    output logic                             byte_valid,
    output logic                             stream_done,
    output logic                             bad_char,
    output logic [b64d_pkg::COUNT_W-1:0]     byte_count
);

    b64d_pkg::phase_t                 phase_reg, phase_next;
    logic [7:0]                       partial_reg, partial_next;
    logic                             error_reg, error_next;
    logic [b64d_pkg::COUNT_W-1:0]     count_reg, count_next;

    logic                             res_valid_reg;
    logic [7:0]                       out_byte_reg, out_byte_next;
    logic                             byte_valid_reg, byte_valid_next;
    logic                             done_reg;
    logic                             bad_reg;
    logic [b64d_pkg::COUNT_W-1:0]     res_count_reg;

    logic                             take;
    logic                             use_sym;

    // The result register frees up when it is empty or being taken this cycle.
    assign room    = !res_valid_reg || !res_stall;
    assign take    = sym_valid && room;
    assign use_sym = (sym.kind == b64d_pkg::SYM_DATA) && !error_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        partial_next    = partial_reg;
        error_next      = error_reg || (sym.kind == b64d_pkg::SYM_BAD);
        count_next      = count_reg;
        out_byte_next   = 8'd0;
        byte_valid_next = 1'b0;
        if (use_sym)
        begin
            unique case (phase_reg)
                b64d_pkg::PH_FIRST:
                begin
                    partial_next = {sym.value, 2'b00};
                end
                b64d_pkg::PH_SECOND:
                begin
                    out_byte_next   = partial_reg | {6'd0, sym.value[5:4]};
                    partial_next    = {sym.value[3:0], 4'd0};
                    byte_valid_next = 1'b1;
                end
                b64d_pkg::PH_THIRD:
                begin
                    out_byte_next   = partial_reg | {4'd0, sym.value[5:2]};
                    partial_next    = {sym.value[1:0], 6'd0};
                    byte_valid_next = 1'b1;
                end
                b64d_pkg::PH_FOURTH:
                begin
                    out_byte_next   = partial_reg | {2'd0, sym.value};
                    partial_next    = 8'd0;
                    byte_valid_next = 1'b1;
                end
                default:
                begin
                    partial_next = partial_reg;
                end
            endcase
            phase_next = b64d_pkg::phase_t'(phase_reg + 2'd1);
            if (byte_valid_next && (count_reg < b64d_pkg::COUNT_LIMIT))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= b64d_pkg::PH_FIRST;
            partial_reg   <= 8'd0;
            error_reg     <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (room)
            begin
                res_valid_reg <= sym_valid;
            end
            if (take)
            begin
                if (sym_last)
                begin
                    phase_reg   <= b64d_pkg::PH_FIRST;
                    partial_reg <= 8'd0;
                    error_reg   <= 1'b0;
                    count_reg   <= '0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    partial_reg <= partial_next;
                    error_reg   <= error_next;
                    count_reg   <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            done_reg       <= sym_last;
            bad_reg        <= error_next;
            res_count_reg  <= count_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign stream_done = done_reg;
    assign bad_char    = bad_reg;
    assign byte_count  = res_count_reg;

endmodule

>>> hdl/base64_lenient_decoder.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+------------------------------------------
// input    | char_valid / char_stall      | in_char[7:0], last_char
// result   | res_valid / res_stall        | out_byte[7:0], byte_valid, stream_done,
//          |                              | bad_char, byte_count[23:0]
//
// One word in, one word out, one word per clock sustained while res_stall is
// low. A word is held in the input register, where it is classified, and moves
// into the result register once that register has room; its result is then
// presented there until taken.
// Reset (rst_n, asynchronous, active low) empties both registers and clears the
// decode state. A stall on a full result register holds it and, when the input
// register is also full, raises char_stall in the same cycle.
module base64_lenient_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             char_valid,
    output logic                             char_stall,
    input  logic [7:0]                       in_char,
    input  logic                             last_char,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [7:0]                       out_byte,
    output logic                             byte_valid,
    output logic                             stream_done,
    output logic                             bad_char,
    output logic [b64d_pkg::COUNT_W-1:0]     byte_count
);

    logic            in_valid_reg;
    logic [7:0]      char_reg;
    logic            last_reg;
    logic            room;
    b64d_pkg::sym_t  sym;

    // The input register moves on whenever the result register can take its word.
    assign char_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_reg <= in_char;
            last_reg <= last_char;
        end
    end

    // Character to 6-bit symbol, skip or bad.
    b64d_classify u_classify (
        .in_char (char_reg),
        .sym     (sym)
    );

    // Bit accumulator, sticky error, byte counter and the result register.
    b64d_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym_valid   (in_valid_reg),
        .sym         (sym),
        .sym_last    (last_reg),
        .room        (room),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .stream_done (stream_done),
        .bad_char    (bad_char),
        .byte_count  (byte_count)
    );

endmodule
